// File: hdl/utf16u8_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
// No dependencies.
package utf16u8_pkg;

	localparam int unsigned UNIT_W = 16;
	localparam int unsigned CP_W   = 21;

	localparam logic [UNIT_W-1:0] UNIT_BOM_SWAPPED = 16'hFFFE;
	localparam logic [UNIT_W-1:0] UNIT_BOM         = 16'hFEFF;
	localparam logic [5:0]        HIGH_SUR_TAG     = 6'b110110;
	localparam logic [4:0]        SUR_TAG          = 5'b11011;
	localparam logic [CP_W-1:0]   SUPP_BASE        = 21'h10000;

	localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007F;
	localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007FF;
	localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00FFFF;

	localparam logic [7:0] LEAD_2B = 8'hC0;
	localparam logic [7:0] LEAD_3B = 8'hE0;
	localparam logic [7:0] LEAD_4B = 8'hF0;
	localparam logic [7:0] CONT_B  = 8'h80;

	// one queued item: up to four bytes, index of the last one, end marker flag
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            eos;
	} entry_t;

	function automatic entry_t encode_cp(input logic [CP_W-1:0] cp);
		entry_t e;
		e = '0;
		priority if (cp <= CP_MAX_1B) begin
			e.bytes[0] = cp[7:0];
			e.last_idx = 2'd0;
		end else if (cp <= CP_MAX_2B) begin
			e.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
			e.bytes[1] = CONT_B | {2'b00, cp[5:0]};
			e.last_idx = 2'd1;
		end else if (cp <= CP_MAX_3B) begin
			e.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
			e.bytes[1] = CONT_B | {2'b00, cp[11:6]};
			e.bytes[2] = CONT_B | {2'b00, cp[5:0]};
			e.last_idx = 2'd2;
		end else begin
			e.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
			e.bytes[1] = CONT_B | {2'b00, cp[17:12]};
			e.bytes[2] = CONT_B | {2'b00, cp[11:6]};
			e.bytes[3] = CONT_B | {2'b00, cp[5:0]};
			e.last_idx = 2'd3;
		end
		return e;
	endfunction

endpackage

// File: hdl/utf16u8_front.sv
`timescale 1ns / 1ps
// Front end: assembles code units, tracks byte order and surrogates, encodes to UTF-8.
// Depends on utf16u8_pkg.
module utf16u8_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             byte_first,
	input  logic [7:0]             byte_second,
	output logic                   push,
	output utf16u8_pkg::entry_t    push_entry
);

	logic       swap_q;
	logic       pend_q;
	logic [9:0] high_bits_q;

	logic [15:0] unit_raw;
	logic [15:0] unit;
	logic        is_zero;
	logic        is_bom;
	logic        is_sur;
	logic        is_high;
	logic [utf16u8_pkg::CP_W-1:0] cp;

	always_comb begin
		unit_raw = swap_q ? {byte_first, byte_second} : {byte_second, byte_first};
		is_zero  = (unit_raw == '0);
		is_bom   = (unit_raw == utf16u8_pkg::UNIT_BOM_SWAPPED);
		unit     = is_bom ? utf16u8_pkg::UNIT_BOM : unit_raw;
		is_sur   = (unit[15:11] == utf16u8_pkg::SUR_TAG);
		is_high  = (unit[15:10] == utf16u8_pkg::HIGH_SUR_TAG);
		if (is_sur) begin
			cp = {1'b0, high_bits_q, unit[9:0]} + utf16u8_pkg::SUPP_BASE;
		end else begin
			cp = {5'b00000, unit};
		end
	end

	// lone low surrogates and high surrogates give nothing
	assign push = accept && (is_zero || !is_sur || (!is_high && pend_q));

	always_comb begin
		if (is_zero) begin
			push_entry = '0;
			push_entry.eos = 1'b1;
		end else begin
			push_entry = utf16u8_pkg::encode_cp(cp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q      <= 1'b0;
			pend_q      <= 1'b0;
			high_bits_q <= '0;
		end else if (accept) begin
			if (is_zero) begin
				swap_q      <= 1'b0;
				pend_q      <= 1'b0;
				high_bits_q <= '0;
			end else begin
				if (is_bom) begin
					swap_q <= !swap_q;
				end
				if (is_high) begin
					pend_q      <= 1'b1;
					high_bits_q <= unit[9:0];
				end else begin
					pend_q      <= 1'b0;
					high_bits_q <= '0;
				end
			end
		end
	end

endmodule

// File: hdl/utf16u8_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue of encoded items between front and back ends.
// Depends on utf16u8_pkg.
module utf16u8_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  utf16u8_pkg::entry_t push_entry,
	input  logic                pop,
	output utf16u8_pkg::entry_t head,
	output logic                empty,
	output logic                full
);

	utf16u8_pkg::entry_t mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/utf16u8_back.sv
`timescale 1ns / 1ps
// Back end: sends queued items one byte per cycle unless stalled; registered output.
// Depends on utf16u8_pkg.
module utf16u8_back (
	input  logic                clk,
	input  logic                arst_n,
	input  utf16u8_pkg::entry_t head,
	input  logic                empty,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic                m_tuser
);

	utf16u8_pkg::entry_t cur_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       user_q;
	logic       out_free;

	assign out_free = !vld_q || m_tready;
	assign pop      = out_free && !busy_q && !empty;

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (out_free) begin
			if (busy_q) begin
				data_q <= cur_q.bytes[idx_q];
				last_q <= (idx_q == cur_q.last_idx);
				user_q <= 1'b0;
			end else if (!empty) begin
				data_q <= head.bytes[0];
				last_q <= (head.last_idx == 2'd0);
				user_q <= head.eos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (out_free) begin
			if (busy_q) begin
				vld_q <= 1'b1;
				if (idx_q == cur_q.last_idx) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end else if (!empty) begin
				vld_q  <= 1'b1;
				busy_q <= (head.last_idx != 2'd0);
				idx_q  <= 2'd1;
			end else begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-16 to UTF-8 transcoder: front end, queue, back end.
// Depends on utf16u8_pkg, utf16u8_front, utf16u8_fifo, utf16u8_back.
//
//  channel | dir | tdata                          | tlast       | tuser
//  s_      | in  | [7:0] byte_first, [15:8] byte_second | -     | -
//  m_      | out | [7:0] out_byte                 | last_of_run | end_of_string
//
// One output byte per cycle when not stalled; a queued item is 1 to 4 bytes (its byte count).
// The front takes a unit every cycle while the two-entry queue has room; high and lone
// low surrogates are taken but give nothing. Reset clears byte order, the held
// surrogate, the queue and the output register. A stalled output fills the queue first.
module utf16_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] byte_first, [15:8] byte_second
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser    // [0] end_of_string
);

	utf16u8_pkg::entry_t push_entry;
	utf16u8_pkg::entry_t head;
	logic push;
	logic pop;
	logic empty;
	logic full;
	logic accept;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	utf16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.byte_first  (s_tdata[7:0]),
		.byte_second (s_tdata[15:8]),
		.push        (push),
		.push_entry  (push_entry)
	);

	utf16u8_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	utf16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: hdl/utf16u8_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the transcoder output stream, bound to the top level.
// Depends on utf16_to_utf8_transcoder.
module utf16u8_props (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// end marker is a lone zero byte closing its run
	a_eos_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'h00 && m_tlast)
		else $error("end marker with nonzero byte or open run");

	// ASCII bytes and the end marker always close a run
	a_ascii_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[7] |-> m_tlast)
		else $error("single-byte sequence not marked last");

	// a lead byte of a multi-byte sequence never closes a run
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7:6] == 2'b11 |-> !m_tlast)
		else $error("lead byte marked last");

	// a stalled output byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output changed under stall");

endmodule

bind utf16_to_utf8_transcoder utf16u8_props u_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
